// ----- hw/rtl/prsr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the pixel RMS and spike rate reducer.
// Holds field widths, sizes, register codes, state types and the front-to-back job type.
package prsr_pkg;

    localparam int NUM_CHANNELS          = 64;
    localparam int MAX_SAMPLES_PER_PIXEL = 64;

    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 6;
    localparam int VALUE_W  = 18;
    localparam int SPP_W    = 7;
    localparam int THR_W    = 16;
    localparam int RATE_W   = 18;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef enum logic [1:0] {
        REG_SPP  = 2'd0,
        REG_MODE = 2'd1,
        REG_THR  = 2'd2,
        REG_RATE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SPP_W-1:0]         spp;
        logic                     mode;
        logic signed [THR_W-1:0]  thr;
        logic [RATE_W-1:0]        rate;
    } cfg_t;

    typedef enum logic {
        F_IDLE,
        F_CALC
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WALK,
        B_PREP,
        B_DIV,
        B_SQRT,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          ch;
        logic [SPP_W-1:0]           n;
        logic signed [SAMPLE_W:0]   mid2;
    } job_t;

    typedef struct packed {
        logic                       en;
        logic [CHAN_W-1:0]          ch;
        logic [SPP_W-1:0]           idx;
        logic signed [SAMPLE_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic full;
        logic hit;
    } q_stat_t;

endpackage

// ----- hw/rtl/prsr_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples in and pixels out.
// Depends on prsr_pkg for the field widths.
interface prsr_smp_if;
    import prsr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CHAN_W-1:0]          channel_index;
    logic signed [SAMPLE_W-1:0] sample_value;
    modport source (output valid, output channel_index, output sample_value, input ready);
    modport sink (input valid, input channel_index, input sample_value, output ready);
endinterface

interface prsr_pix_if;
    import prsr_pkg::*;
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  pixel_channel;
    logic [VALUE_W-1:0] pixel_value;
    modport source (output valid, output pixel_channel, output pixel_value, input ready);
    modport sink (input valid, input pixel_channel, input pixel_value, output ready);
endinterface

// ----- hw/rtl/prsr_front.sv -----
`timescale 1ns / 1ps
// Front part: accepts samples, keeps per-channel fill count, minimum and maximum,
// writes the sample store and issues one job per completed pixel. Uses prsr_pkg.
module prsr_front import prsr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    prsr_smp_if.sink          smp,
    input  cfg_t              cfg,
    input  q_stat_t           q_stat,
    input  logic              back_hit,
    output logic [CHAN_W-1:0] query_ch,
    output logic              push,
    output job_t              push_job,
    output store_wr_t         st_wr
);

    localparam int CI_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [SPP_W-1:0]           fill_mem [NUM_CHANNELS];
    logic signed [SAMPLE_W-1:0] min_mem  [NUM_CHANNELS];
    logic signed [SAMPLE_W-1:0] max_mem  [NUM_CHANNELS];

    front_state_t               state_reg, state_next;
    logic [NUM_CHANNELS-1:0]    fvld_reg, fvld_next;
    logic [CHAN_W-1:0]          ch_reg;
    logic signed [SAMPLE_W-1:0] s_reg;
    logic [SPP_W-1:0]           fill_rd_reg;
    logic signed [SAMPLE_W-1:0] min_rd_reg;
    logic signed [SAMPLE_W-1:0] max_rd_reg;
    logic                       vld_rd_reg;

    logic                       accept;
    logic                       in_range;
    logic [CI_W-1:0]            ci_in;
    logic [CI_W-1:0]            ci_reg;
    logic [SPP_W-1:0]           spp_eff;
    logic [SPP_W-1:0]           fill;
    logic [SPP_W-1:0]           n;
    logic                       done;
    logic signed [SAMPLE_W-1:0] new_min;
    logic signed [SAMPLE_W-1:0] new_max;

    assign query_ch = smp.channel_index;
    assign in_range = (32'(smp.channel_index) < NUM_CHANNELS);
    assign ci_in    = CI_W'(smp.channel_index);
    assign ci_reg   = CI_W'(ch_reg);
    assign smp.ready = (state_reg == F_IDLE) && !q_stat.full && !q_stat.hit && !back_hit;
    assign accept   = smp.valid && smp.ready;

    always_comb
    begin
        if (cfg.spp == '0)
        begin
            spp_eff = SPP_W'(1);
        end
        else if (32'(cfg.spp) > MAX_SAMPLES_PER_PIXEL)
        begin
            spp_eff = SPP_W'(MAX_SAMPLES_PER_PIXEL);
        end
        else
        begin
            spp_eff = cfg.spp;
        end
    end

    always_comb
    begin
        fill    = vld_rd_reg ? fill_rd_reg : '0;
        new_min = ((fill == '0) || (s_reg < min_rd_reg)) ? s_reg : min_rd_reg;
        new_max = ((fill == '0) || (s_reg > max_rd_reg)) ? s_reg : max_rd_reg;
        n       = fill + SPP_W'(1);
        done    = (n >= spp_eff);
    end

    always_comb
    begin
        state_next = state_reg;
        fvld_next  = fvld_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && in_range)
                begin
                    state_next = F_CALC;
                end
            end
            F_CALC:
            begin
                push             = done;
                fvld_next[ci_reg] = 1'b1;
                state_next       = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign st_wr.en       = (state_reg == F_CALC);
    assign st_wr.ch       = ch_reg;
    assign st_wr.idx      = fill;
    assign st_wr.data     = s_reg;
    assign push_job.ch    = ch_reg;
    assign push_job.n     = n;
    assign push_job.mid2  = (SAMPLE_W+1)'(new_max) + (SAMPLE_W+1)'(new_min);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            fvld_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fvld_reg  <= fvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            ch_reg      <= smp.channel_index;
            s_reg       <= smp.sample_value;
            fill_rd_reg <= fill_mem[ci_in];
            min_rd_reg  <= min_mem[ci_in];
            max_rd_reg  <= max_mem[ci_in];
            vld_rd_reg  <= fvld_reg[ci_in];
        end
        if (state_reg == F_CALC)
        begin
            fill_mem[ci_reg] <= done ? '0 : n;
            min_mem[ci_reg]  <= new_min;
            max_mem[ci_reg]  <= new_max;
        end
    end

endmodule

// ----- hw/rtl/prsr_queue.sv -----
`timescale 1ns / 1ps
// Two-entry job queue between the front and back parts.
// Also reports whether a queued job belongs to a queried channel. Uses prsr_pkg.
module prsr_queue import prsr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  job_t              push_job,
    input  logic              pop,
    input  logic [CHAN_W-1:0] query_ch,
    output q_stat_t           q_stat,
    output logic              head_valid,
    output job_t              head_job
);

    job_t       ent_reg [2];
    logic [1:0] vld_reg, vld_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;

    assign head_valid  = vld_reg[rd_ptr_reg];
    assign head_job    = ent_reg[rd_ptr_reg];
    assign q_stat.full = &vld_reg;
    assign q_stat.hit  = (vld_reg[0] && (ent_reg[0].ch == query_ch)) ||
                         (vld_reg[1] && (ent_reg[1].ch == query_ch));

    always_comb
    begin
        vld_next    = vld_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (pop && head_valid)
        begin
            vld_next[rd_ptr_reg] = 1'b0;
            rd_ptr_next          = !rd_ptr_reg;
        end
        if (push)
        begin
            vld_next[wr_ptr_reg] = 1'b1;
            wr_ptr_next          = !wr_ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= vld_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hw/rtl/prsr_back.sv -----
`timescale 1ns / 1ps
// Back part: holds the sample store, walks a completed pixel, then divides and
// takes the square root or scales the spike count. Uses prsr_pkg.
module prsr_back import prsr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  store_wr_t         st_wr,
    input  logic              head_valid,
    input  job_t              head_job,
    output logic              pop,
    input  logic [CHAN_W-1:0] query_ch,
    output logic              back_hit,
    prsr_pix_if.source        pix
);

    localparam int DEPTH  = NUM_CHANNELS * MAX_SAMPLES_PER_PIXEL;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW     = SAMPLE_W + 2;
    localparam int PW     = 2 * DW - 2;
    localparam int SUM_W  = PW + SPP_W;
    localparam int DIV_W  = SUM_W - 2;
    localparam int IT_W   = $clog2(DIV_W + 1);
    localparam int SQ_W   = PW;

    logic signed [SAMPLE_W-1:0] store_mem [DEPTH];

    back_state_t                state_reg, state_next;
    job_t                       job_reg, job_next;
    logic                       active_reg, active_next;
    logic [SPP_W-1:0]           rd_cnt_reg, rd_cnt_next;
    logic                       v1_reg, v1_next;
    logic                       v2_reg, v2_next;
    logic signed [SAMPLE_W-1:0] data_reg;
    logic [PW-1:0]              prod_reg, prod_next;
    logic                       spk_reg, spk_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [SPP_W-1:0]           cnt_reg, cnt_next;
    logic [DIV_W-1:0]           quo_reg, quo_next;
    logic [SPP_W-1:0]           rem_reg, rem_next;
    logic [IT_W-1:0]            it_reg, it_next;
    logic [SQ_W-1:0]            sqx_reg, sqx_next;
    logic [SQ_W-1:0]            sqr_reg, sqr_next;
    logic [SQ_W-1:0]            sqb_reg, sqb_next;
    logic [VALUE_W-1:0]         val_reg, val_next;
    logic                       ovld_reg, ovld_next;
    logic [CHAN_W-1:0]          och_reg, och_next;
    logic [VALUE_W-1:0]         oval_reg, oval_next;

    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic signed [DW-1:0]       d;
    logic signed [DW-1:0]       thr2;
    logic signed [2*DW-1:0]     sq;
    logic [SPP_W:0]             rem_sh;
    logic                       div_ge;
    logic [SQ_W-1:0]            sq_t;
    logic [DIV_W-1:0]           rate_ext;
    logic [SPP_W+RATE_W-1:0]    cnt_rate;

    assign wr_addr  = AW'(32'(st_wr.ch) * MAX_SAMPLES_PER_PIXEL + 32'(st_wr.idx));
    assign rd_addr  = AW'(32'(job_reg.ch) * MAX_SAMPLES_PER_PIXEL + 32'(rd_cnt_reg));
    assign back_hit = active_reg && (job_reg.ch == query_ch);

    assign d        = DW'(signed'({data_reg, 1'b0})) - DW'(job_reg.mid2);
    assign thr2     = DW'(signed'({cfg.thr, 1'b0}));
    assign sq       = d * d;
    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge   = (rem_sh >= {1'b0, job_reg.n});
    assign sq_t     = sqr_reg + sqb_reg;
    assign rate_ext = DIV_W'(cfg.rate);
    assign cnt_rate = cnt_reg * cfg.rate;

    assign pix.valid         = ovld_reg;
    assign pix.pixel_channel = och_reg;
    assign pix.pixel_value   = oval_reg;

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        active_next = active_reg;
        rd_cnt_next = rd_cnt_reg;
        v1_next     = 1'b0;
        v2_next     = 1'b0;
        prod_next   = prod_reg;
        spk_next    = spk_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        it_next     = it_reg;
        sqx_next    = sqx_reg;
        sqr_next    = sqr_reg;
        sqb_next    = sqb_reg;
        val_next    = val_reg;
        ovld_next   = ovld_reg && !pix.ready;
        och_next    = och_reg;
        oval_next   = oval_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    pop         = 1'b1;
                    job_next    = head_job;
                    active_next = 1'b1;
                    rd_cnt_next = '0;
                    sum_next    = '0;
                    cnt_next    = '0;
                    state_next  = B_WALK;
                end
            end
            B_WALK:
            begin
                if (rd_cnt_reg < job_reg.n)
                begin
                    rd_en       = 1'b1;
                    rd_cnt_next = rd_cnt_reg + SPP_W'(1);
                    v1_next     = 1'b1;
                end
                if (v1_reg)
                begin
                    prod_next = sq[PW-1:0];
                    spk_next  = (d < thr2);
                    v2_next   = 1'b1;
                end
                if (v2_reg)
                begin
                    sum_next = sum_reg + SUM_W'(prod_reg);
                    cnt_next = cnt_reg + SPP_W'(spk_reg);
                end
                if ((rd_cnt_reg == job_reg.n) && !v1_reg && !v2_reg)
                begin
                    state_next = B_PREP;
                end
            end
            B_PREP:
            begin
                quo_next   = cfg.mode ? DIV_W'(cnt_rate) : sum_reg[SUM_W-1:2];
                rem_next   = '0;
                it_next    = IT_W'(DIV_W);
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (it_reg != '0)
                begin
                    rem_next = div_ge ? SPP_W'(rem_sh - {1'b0, job_reg.n}) : rem_sh[SPP_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], div_ge};
                    it_next  = it_reg - IT_W'(1);
                end
                else if (cfg.mode)
                begin
                    val_next   = (quo_reg > rate_ext) ? cfg.rate : quo_reg[VALUE_W-1:0];
                    state_next = B_OUT;
                end
                else
                begin
                    sqx_next   = quo_reg[SQ_W-1:0];
                    sqr_next   = '0;
                    sqb_next   = SQ_W'(1) << (SQ_W - 2);
                    state_next = B_SQRT;
                end
            end
            B_SQRT:
            begin
                if (sqb_reg != '0)
                begin
                    if (sqx_reg >= sq_t)
                    begin
                        sqx_next = sqx_reg - sq_t;
                        sqr_next = (sqr_reg >> 1) + sqb_reg;
                    end
                    else
                    begin
                        sqr_next = sqr_reg >> 1;
                    end
                    sqb_next = sqb_reg >> 2;
                end
                else
                begin
                    val_next   = sqr_reg[VALUE_W-1:0];
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!ovld_reg || pix.ready)
                begin
                    ovld_next   = 1'b1;
                    och_next    = job_reg.ch;
                    oval_next   = val_reg;
                    active_next = 1'b0;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            active_reg <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            ovld_reg   <= 1'b0;
            rd_cnt_reg <= '0;
            it_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            ovld_reg   <= ovld_next;
            rd_cnt_reg <= rd_cnt_next;
            it_reg     <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        prod_reg <= prod_next;
        spk_reg  <= spk_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        sqx_reg  <= sqx_next;
        sqr_reg  <= sqr_next;
        sqb_reg  <= sqb_next;
        val_reg  <= val_next;
        och_reg  <= och_next;
        oval_reg <= oval_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_wr.en)
        begin
            store_mem[wr_addr] <= st_wr.data;
        end
        if (rd_en)
        begin
            data_reg <= store_mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/pixel_rms_spike_rate_reducer.sv -----
`timescale 1ns / 1ps
// Top level of the pixel reducer: configuration registers, front, job queue and back.
// Depends on prsr_pkg, prsr_if, prsr_front, prsr_queue and prsr_back.
//
// The front takes a sample beat and, before it takes the next, updates the channel's
// fill count, minimum and maximum and writes the sample store. A completed pixel
// is queued for the back, which walks the store at one sample a cycle, then runs
// a one-bit-a-cycle divider and, in RMS mode, a two-bits-a-cycle square root.
// A sample for a channel whose previous pixel is still queued or being reduced
// waits until the back has passed that pixel to its output register.
module pixel_rms_spike_rate_reducer import prsr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    prsr_smp_if.sink           smp,
    prsr_pix_if.source         pix,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [SPP_W-1:0]        spp_reg;
    logic                    mode_reg;
    logic signed [THR_W-1:0] thr_reg;
    logic [RATE_W-1:0]       rate_reg;
    reg_idx_t                reg_idx;
    logic                    wr_en;
    cfg_t                    cfg;

    logic                    push;
    job_t                    push_job;
    logic                    pop;
    logic                    head_valid;
    job_t                    head_job;
    q_stat_t                 q_stat;
    logic [CHAN_W-1:0]       query_ch;
    logic                    back_hit;
    store_wr_t               st_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    assign cfg.spp  = spp_reg;
    assign cfg.mode = mode_reg;
    assign cfg.thr  = thr_reg;
    assign cfg.rate = rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg  <= SPP_W'(1);
            mode_reg <= 1'b0;
            thr_reg  <= '0;
            rate_reg <= RATE_W'(30000);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SPP:  spp_reg  <= pwdata[SPP_W-1:0];
                REG_MODE: mode_reg <= pwdata[0];
                REG_THR:  thr_reg  <= pwdata[THR_W-1:0];
                REG_RATE: rate_reg <= pwdata[RATE_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SPP:  prdata = PDATA_W'(spp_reg);
            REG_MODE: prdata = PDATA_W'(mode_reg);
            REG_THR:  prdata = PDATA_W'(unsigned'(thr_reg));
            REG_RATE: prdata = PDATA_W'(rate_reg);
            default:  prdata = '0;
        endcase
    end

    prsr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .smp      (smp),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .back_hit (back_hit),
        .query_ch (query_ch),
        .push     (push),
        .push_job (push_job),
        .st_wr    (st_wr)
    );

    prsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .query_ch   (query_ch),
        .q_stat     (q_stat),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    prsr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .st_wr      (st_wr),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .query_ch   (query_ch),
        .back_hit   (back_hit),
        .pix        (pix)
    );

endmodule

// ----- hw/rtl/prsr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the pixel reducer and its bind to the top level.
// Depends on prsr_pkg and pixel_rms_spike_rate_reducer.
module prsr_checker import prsr_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [CHAN_W-1:0]  out_ch,
    input logic [VALUE_W-1:0] out_value,
    input logic               pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ch) && $stable(out_value))
        else $error("Pixel beat changed while stalled.");

    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Sample beat accepted on two consecutive cycles.");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("Configuration port inserted a wait state.");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("Pixel beat present right after reset.");

endmodule

bind pixel_rms_spike_rate_reducer prsr_checker u_prsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (smp.valid),
    .in_ready  (smp.ready),
    .out_valid (pix.valid),
    .out_ready (pix.ready),
    .out_ch    (pix.pixel_channel),
    .out_value (pix.pixel_value),
    .pready    (pready)
);

// ----- tb/tb_pixel_rms_spike_rate_reducer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pixel_rms_spike_rate_reducer: predicts every pixel from the
// accepted sample beats and checks the pixel beats in order. Depends on prsr_pkg and prsr_if.
module tb_pixel_rms_spike_rate_reducer;
    import prsr_pkg::*;

    localparam int NCH        = 64;
    localparam int MAXN       = 64;
    localparam int SETTLE     = 200;
    localparam int CYCLE_CAP  = 600000;
    localparam bit MODE_RMS   = 1'b0;
    localparam bit MODE_SPIKE = 1'b1;

    typedef struct {
        logic [CHAN_W-1:0]  ch;
        logic [VALUE_W-1:0] value;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    prsr_smp_if smp ();
    prsr_pix_if pix ();

    pixel_rms_spike_rate_reducer dut (
        .clk(clk), .rst_n(rst_n), .smp(smp.sink), .pix(pix.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model state and configuration.
    int unsigned               m_fill [NCH];
    logic signed [SAMPLE_W-1:0] m_min [NCH];
    logic signed [SAMPLE_W-1:0] m_max [NCH];
    logic signed [SAMPLE_W-1:0] m_store [NCH][MAXN];
    logic [SPP_W-1:0]          m_spp;
    logic                      m_mode;
    logic signed [THR_W-1:0]   m_thr;
    logic [RATE_W-1:0]         m_rate;

    pixel_t expected_pixels[$];
    int     errors = 0;
    int     cycles = 0;
    bit     sink_busy_phase;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic reduce_sample(input logic [CHAN_W-1:0] ch,
                                 input logic signed [SAMPLE_W-1:0] s);
        int unsigned     fill;
        int unsigned     n;
        int unsigned     spp;
        longint          mid2;
        longint          d;
        longint          thr2;
        longint unsigned acc;
        longint unsigned val;
        pixel_t          px;
        spp = m_spp;
        if (spp == 0)
            spp = 1;
        if (spp > MAXN)
            spp = MAXN;
        fill = m_fill[ch];
        if (fill >= MAXN)
            fill = MAXN - 1;
        m_store[ch][fill] = s;
        if (fill == 0)
        begin
            m_min[ch] = s;
            m_max[ch] = s;
        end
        else
        begin
            if (s > m_max[ch])
                m_max[ch] = s;
            if (s < m_min[ch])
                m_min[ch] = s;
        end
        n = fill + 1;
        if (n < spp)
        begin
            m_fill[ch] = n;
            return;
        end
        m_fill[ch] = 0;
        mid2 = longint'(m_max[ch]) + longint'(m_min[ch]);
        thr2 = 2 * longint'(m_thr);
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            d = 2 * longint'(m_store[ch][i]) - mid2;
            if (m_mode == MODE_RMS)
                acc += longint'(d * d);
            else if (d < thr2)
                acc++;
        end
        if (m_mode == MODE_RMS)
            val = int_sqrt(acc / (4 * n));
        else
        begin
            val = (acc * m_rate) / n;
            if (val > m_rate)
                val = m_rate;
        end
        px.ch = ch;
        px.value = val[VALUE_W-1:0];
        expected_pixels.insert(expected_pixels.size(), px);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sink_busy_phase == 1'b0 || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Pixel sink: checks each accepted beat and stalls at random.
    int ready_hold = 0;
    always @(posedge clk)
    begin
        if (rst_n && pix.valid && pix.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel ch %0d value %0d", $time,
                         pix.pixel_channel, pix.pixel_value);
                errors++;
            end
            else
            begin
                if (pix.pixel_channel !== expected_pixels[0].ch)
                begin
                    $display("%0t: pixel_channel expected %0d actual %0d", $time,
                             expected_pixels[0].ch, pix.pixel_channel);
                    errors++;
                end
                if (pix.pixel_value !== expected_pixels[0].value)
                begin
                    $display("%0t: pixel_value expected %0d actual %0d", $time,
                             expected_pixels[0].value, pix.pixel_value);
                    errors++;
                end
                void'(expected_pixels.pop_front());
            end
        end
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            pix.ready <= 1'b0;
        end
        else
        begin
            ready_hold <= pick_gap();
            pix.ready <= 1'b1;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SPP:  m_spp = data[SPP_W-1:0];
            REG_MODE: m_mode = data[0];
            REG_THR:  m_thr = data[THR_W-1:0];
            REG_RATE: m_rate = data[RATE_W-1:0];
            default:  ;
        endcase
    endtask

    task automatic configure(input int spp, input bit mode, input int thr, input int rate);
        write_reg(REG_SPP, spp);
        write_reg(REG_MODE, PDATA_W'(mode));
        write_reg(REG_THR, thr);
        write_reg(REG_RATE, rate);
    endtask

    task automatic send_sample(input int ch, input int s);
        int gap;
        smp.valid <= 1'b1;
        smp.channel_index <= ch[CHAN_W-1:0];
        smp.sample_value <= s[SAMPLE_W-1:0];
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        reduce_sample(ch[CHAN_W-1:0], s[SAMPLE_W-1:0]);
        gap = pick_gap();
        if (gap > 0)
        begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_single_sample_pixels();
        configure(1, MODE_RMS, 0, 30000);
        send_sample(0, -32768);
        send_sample(63, 32767);
        drain();
        configure(0, MODE_SPIKE, 0, 30000);
        send_sample(5, 0);
        drain();
    endtask

    task automatic test_extreme_span();
        configure(2, MODE_RMS, 0, 30000);
        send_sample(1, -32768);
        send_sample(1, 32767);
        send_sample(2, 100);
        send_sample(2, 100);
        drain();
    endtask

    task automatic test_spike_edges();
        configure(3, MODE_SPIKE, 32767, 262143);
        send_sample(4, -32768);
        send_sample(4, 0);
        send_sample(4, 32767);
        drain();
        configure(3, MODE_SPIKE, -32768, 0);
        send_sample(4, -5);
        send_sample(4, 7);
        send_sample(4, 9);
        drain();
        configure(2, MODE_SPIKE, -1, 1);
        send_sample(6, -32768);
        send_sample(6, 32767);
        drain();
    endtask

    task automatic test_spp_limits();
        configure(100, MODE_RMS, 0, 30000);
        for (int i = 0; i < 64; i++)
            send_sample(7, (i * 1031) - 32768);
        drain();
    endtask

    task automatic test_shrink_mid_pixel();
        configure(8, MODE_RMS, 0, 30000);
        for (int i = 0; i < 5; i++)
            send_sample(3, i * 300 - 700);
        drain();
        write_reg(REG_SPP, 2);
        send_sample(3, 12345);
        drain();
    endtask

    task automatic test_random_phases();
        int spp;
        int ch;
        int s;
        int rate;
        int thr;
        for (int p = 0; p < 9; p++)
        begin
            sink_busy_phase = (p % 3) != 2;
            spp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
            thr = $urandom_range(0, 65535) - 32768;
            rate = $urandom_range(0, 262143);
            if (p == 0)
            begin
                spp = 1;
                thr = -32768;
                rate = 262143;
            end
            else if (p == 1)
            begin
                spp = 64;
                thr = 32767;
                rate = 1;
            end
            configure(spp, 1'($urandom_range(0, 1)), thr, rate);
            for (int i = 0; i < 50; i++)
            begin
                ch = (p % 2) ? $urandom_range(0, 63) : $urandom_range(0, 3);
                s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) - 32768
                                                : $urandom_range(0, 200) - 100;
                send_sample(ch, s);
                if (p == 3 && i == 25)
                    drain();
            end
            drain();
        end
        sink_busy_phase = 1'b1;
    endtask

    initial
    begin
        sink_busy_phase = 1'b1;
        m_spp = 1;
        m_mode = MODE_RMS;
        m_thr = 0;
        m_rate = 30000;
        for (int c = 0; c < NCH; c++)
            m_fill[c] = 0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        smp.valid <= 1'b0;
        smp.channel_index <= '0;
        smp.sample_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_sample_pixels();
        test_extreme_span();
        test_spike_edges();
        test_shrink_mid_pixel();
        test_spp_limits();
        test_random_phases();
        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
